/* hw/rtl/nft_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the neighbor filter table
// no dependencies
package nft_pkg;

  localparam int NFT_TABLE_ENTRIES = 16;
  localparam int IP_W  = 32;
  localparam int MAC_W = 48;
  localparam int LEN_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [IP_W-1:0] BCAST_IP  = '1;
  localparam logic [7:0]      PROTO_UDP = 8'd17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NET_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GW_ADDR  = 2'd2;

  typedef enum logic [2:0] {
    ST_UDP        = 3'd0,
    ST_NOT_US     = 3'd1,
    ST_BAD_LEN    = 3'd2,
    ST_BAD_PROTO  = 3'd3,
    ST_RESOLVED   = 3'd4,
    ST_UNRESOLVED = 3'd5
  } nft_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } nft_state_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } nft_entry_t;

  typedef struct packed {
    logic       en;
    nft_entry_t entry;
  } nft_wr_t;

endpackage

/* hw/rtl/nft_if.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces for request and result words
// depends on nft_pkg
interface nft_in_if;
  import nft_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [IP_W-1:0]   dest_ip;
  logic [IP_W-1:0]   source_ip;
  logic [MAC_W-1:0]  source_mac;
  logic [3:0]        header_words;
  logic [LEN_W-1:0]  bytes_available;
  logic [7:0]        protocol;

  modport source (output valid, kind, dest_ip, source_ip, source_mac, header_words,
                  bytes_available, protocol, input ready);
  modport sink   (input valid, kind, dest_ip, source_ip, source_mac, header_words,
                  bytes_available, protocol, output ready);
endinterface

interface nft_out_if;
  import nft_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic              table_full;
  logic [IP_W-1:0]   next_hop_ip;
  logic [MAC_W-1:0]  next_hop_mac;
  logic [15:0]       ip_ident;

  modport source (output valid, status, table_full, next_hop_ip, next_hop_mac, ip_ident,
                  input ready);
  modport sink   (input valid, status, table_full, next_hop_ip, next_hop_mac, ip_ident,
                  output ready);
endinterface

/* hw/rtl/nft_table_mem.sv */
`timescale 1ns / 1ps
// neighbor table storage: one-port-read one-port-write memory, registered read
// entry 0 (broadcast) kept in flops; depends on nft_pkg
module nft_table_mem #(
  parameter int TABLE_ENTRIES = nft_pkg::NFT_TABLE_ENTRIES,
  localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output nft_pkg::nft_entry_t rd_data,
  input  nft_pkg::nft_wr_t    wr,
  input  logic [IDX_W-1:0]    wr_addr
);
  import nft_pkg::*;

  nft_entry_t       mem_r [TABLE_ENTRIES];
  nft_entry_t       q_r;
  logic             zero_r;
  logic [MAC_W-1:0] mac0_r;

  always_ff @(posedge clk) begin
    if (wr.en && (wr_addr != '0)) begin
      mem_r[wr_addr] <= wr.entry;
    end
    if (rd_en) begin
      q_r    <= mem_r[rd_addr];
      zero_r <= (rd_addr == '0);
    end
  end

  // broadcast entry: address fixed, mac may be relearned
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac0_r <= '1;
    end else if (wr.en && (wr_addr == '0)) begin
      mac0_r <= wr.entry.mac;
    end
  end

  always_comb begin
    rd_data = q_r;
    if (zero_r) begin
      rd_data.ip  = BCAST_IP;
      rd_data.mac = mac0_r;
    end
  end

endmodule

/* hw/rtl/nft_ctrl.sv */
`timescale 1ns / 1ps
// sequencer: receive filter, route, table scan, learn and result register
// depends on nft_pkg, nft_if and drives nft_table_mem
module nft_ctrl #(
  parameter int TABLE_ENTRIES = nft_pkg::NFT_TABLE_ENTRIES,
  localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [nft_pkg::IP_W-1:0]   own_ip,
  input  logic [nft_pkg::IP_W-1:0]   net_mask,
  input  logic [nft_pkg::IP_W-1:0]   gw_addr,
  nft_in_if.sink                     in_ch,
  nft_out_if.source                  out_ch,
  output logic                       rd_en,
  output logic [IDX_W-1:0]           rd_addr,
  input  nft_pkg::nft_entry_t        rd_data,
  output nft_pkg::nft_wr_t           wr,
  output logic [IDX_W-1:0]           wr_addr
);
  import nft_pkg::*;

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(TABLE_ENTRIES);

  nft_state_t       state_r, state_nxt;
  logic             kind_r, kind_nxt;
  logic             learn_r, learn_nxt;
  logic [IP_W-1:0]  key_r, key_nxt;
  logic [MAC_W-1:0] smac_r, smac_nxt;
  logic [IP_W-1:0]  hop_r, hop_nxt;
  nft_status_t      status_r, status_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             cmp_valid_r, cmp_valid_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] found_idx_r, found_idx_nxt;
  logic [MAC_W-1:0] found_mac_r, found_mac_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      ident_r, ident_nxt;

  logic             out_valid_r, out_valid_nxt;
  nft_status_t      out_status_r, out_status_nxt;
  logic             out_full_r, out_full_nxt;
  logic [IP_W-1:0]  out_hop_ip_r, out_hop_ip_nxt;
  logic [MAC_W-1:0] out_hop_mac_r, out_hop_mac_nxt;
  logic [15:0]      out_ident_r, out_ident_nxt;

  logic             hit;
  logic [IP_W-1:0]  route_ip;
  logic [5:0]       hdr_bytes;

  assign in_ch.ready = (state_r == S_IDLE);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.table_full   = out_full_r;
  assign out_ch.next_hop_ip  = out_hop_ip_r;
  assign out_ch.next_hop_mac = out_hop_mac_r;
  assign out_ch.ip_ident     = out_ident_r;

  assign hit       = cmp_valid_r && (rd_data.ip == key_r);
  assign hdr_bytes = {in_ch.header_words, 2'b00};
  assign route_ip  = ((in_ch.dest_ip & net_mask) == (gw_addr & net_mask)) ?
                     in_ch.dest_ip : gw_addr;

  always_comb begin
    state_nxt       = state_r;
    kind_nxt        = kind_r;
    learn_nxt       = learn_r;
    key_nxt         = key_r;
    smac_nxt        = smac_r;
    hop_nxt         = hop_r;
    status_nxt      = status_r;
    rd_idx_nxt      = rd_idx_r;
    cmp_valid_nxt   = cmp_valid_r;
    cmp_idx_nxt     = cmp_idx_r;
    found_nxt       = found_r;
    found_idx_nxt   = found_idx_r;
    found_mac_nxt   = found_mac_r;
    count_nxt       = count_r;
    ident_nxt       = ident_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_full_nxt    = out_full_r;
    out_hop_ip_nxt  = out_hop_ip_r;
    out_hop_mac_nxt = out_hop_mac_r;
    out_ident_nxt   = out_ident_r;
    rd_en           = 1'b0;
    rd_addr         = rd_idx_r[IDX_W-1:0];
    wr.en           = 1'b0;
    wr.entry.ip     = key_r;
    wr.entry.mac    = smac_r;
    wr_addr         = found_idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt      = in_ch.kind;
          smac_nxt      = in_ch.source_mac;
          rd_idx_nxt    = '0;
          cmp_valid_nxt = 1'b0;
          found_nxt     = 1'b0;
          learn_nxt     = 1'b0;
          hop_nxt       = '0;
          if (!in_ch.kind) begin
            key_nxt = in_ch.source_ip;
            if ((in_ch.dest_ip != own_ip) && (in_ch.dest_ip != BCAST_IP)) begin
              status_nxt = ST_NOT_US;
              state_nxt  = S_DONE;
            end else if ({10'b0, hdr_bytes} > in_ch.bytes_available) begin
              status_nxt = ST_BAD_LEN;
              state_nxt  = S_DONE;
            end else begin
              learn_nxt  = 1'b1;
              status_nxt = (in_ch.protocol == PROTO_UDP) ? ST_UDP : ST_BAD_PROTO;
              state_nxt  = S_SEARCH;
            end
          end else begin
            key_nxt    = route_ip;
            hop_nxt    = route_ip;
            status_nxt = ST_UNRESOLVED;
            state_nxt  = S_SEARCH;
          end
        end
      end

      // one read issued and one compare made per cycle
      S_SEARCH: begin
        if (hit) begin
          found_nxt     = 1'b1;
          found_idx_nxt = cmp_idx_r;
          found_mac_nxt = rd_data.mac;
          cmp_valid_nxt = 1'b0;
          state_nxt     = S_DONE;
        end else if (rd_idx_r < count_r) begin
          rd_en         = 1'b1;
          rd_idx_nxt    = rd_idx_r + CNT_W'(1);
          cmp_valid_nxt = 1'b1;
          cmp_idx_nxt   = rd_idx_r[IDX_W-1:0];
        end else begin
          cmp_valid_nxt = 1'b0;
          state_nxt     = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_full_nxt  = 1'b0;
          state_nxt     = S_IDLE;
          if (kind_r) begin
            out_status_nxt  = found_r ? ST_RESOLVED : ST_UNRESOLVED;
            out_hop_ip_nxt  = hop_r;
            out_hop_mac_nxt = found_r ? found_mac_r : '0;
            out_ident_nxt   = ident_r;
            ident_nxt       = ident_r + 16'd1;
          end else begin
            out_status_nxt  = status_r;
            out_hop_ip_nxt  = '0;
            out_hop_mac_nxt = '0;
            out_ident_nxt   = '0;
            if (learn_r) begin
              if (found_r) begin
                wr.en = 1'b1;
              end else if (count_r < ENTRIES_C) begin
                wr.en     = 1'b1;
                wr_addr   = count_r[IDX_W-1:0];
                count_nxt = count_r + CNT_W'(1);
              end else begin
                out_full_nxt = 1'b1;
              end
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cmp_valid_r <= 1'b0;
      count_r     <= CNT_W'(1);
      ident_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      count_r     <= count_nxt;
      ident_r     <= ident_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    learn_r       <= learn_nxt;
    key_r         <= key_nxt;
    smac_r        <= smac_nxt;
    hop_r         <= hop_nxt;
    status_r      <= status_nxt;
    rd_idx_r      <= rd_idx_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    found_r       <= found_nxt;
    found_idx_r   <= found_idx_nxt;
    found_mac_r   <= found_mac_nxt;
    out_status_r  <= out_status_nxt;
    out_full_r    <= out_full_nxt;
    out_hop_ip_r  <= out_hop_ip_nxt;
    out_hop_mac_r <= out_hop_mac_nxt;
    out_ident_r   <= out_ident_nxt;
  end

endmodule

/* hw/rtl/ip_neighbor_filter_table.sv */
`timescale 1ns / 1ps
// sequence: a dropped receive word goes from S_IDLE to S_DONE and then into the result register
//   without a scan; any other word scans the table one entry per cycle, up to every valid entry
// flow: one word at a time, the next word is taken only back in S_IDLE; the single memory
//   read port paces the scan
// reset: synchronous active-low rst_n; one valid entry (broadcast), ident counter and
//   configuration registers at zero, result channel empty; no clearing pass
module ip_neighbor_filter_table #(
  parameter int TABLE_ENTRIES = nft_pkg::NFT_TABLE_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  nft_in_if.sink                          in_ch,
  nft_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [nft_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nft_pkg::IP_W-1:0]        cfg_wdata
);
  import nft_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  // configuration registers: the user writes them only while idle; nothing in the block enforces it
  logic [IP_W-1:0] own_ip_r;
  logic [IP_W-1:0] net_mask_r;
  logic [IP_W-1:0] gw_addr_r;

  // memory port between sequencer and table
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  nft_entry_t       rd_data;
  nft_wr_t          wr;
  logic [IDX_W-1:0] wr_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r   <= '0;
      net_mask_r <= '0;
      gw_addr_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_IP:   own_ip_r   <= cfg_wdata;
        CFG_NET_MASK: net_mask_r <= cfg_wdata;
        CFG_GW_ADDR:  gw_addr_r  <= cfg_wdata;
        default: begin
          // unknown index: write dropped
        end
      endcase
    end
  end

  // sequencer: filters receive words, routes transmit words, scans and learns
  nft_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .own_ip      (own_ip_r),
    .net_mask    (net_mask_r),
    .gw_addr     (gw_addr_r),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr          (wr),
    .wr_addr     (wr_addr)
  );

  // neighbor table: entry 0 holds the broadcast mapping in flops
  nft_table_mem #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr),
    .wr_addr (wr_addr)
  );

endmodule

/* hw/rtl/nft_chk.sv */
`timescale 1ns / 1ps
// port-level assertions for the neighbor filter table, bound to the top level
// depends on nft_pkg and ip_neighbor_filter_table
module nft_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [2:0]                   out_status,
  input logic                         out_table_full,
  input logic [nft_pkg::MAC_W-1:0]    out_next_hop_mac,
  input logic [15:0]                  out_ip_ident
);
  import nft_pkg::*;

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_ip_ident))
    else $error("result word changed while stalled");

  // one word in flight: no acceptance right after one
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while previous one in progress");

  // drops and transmit words never report a full table
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOT_US || out_status == ST_BAD_LEN ||
                  out_status == ST_RESOLVED || out_status == ST_UNRESOLVED)
    |-> !out_table_full)
    else $error("table full flagged on wrong status");

  // unresolved next hop carries no mac
  a_unres: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_UNRESOLVED |-> out_next_hop_mac == '0)
    else $error("unresolved next hop with mac");

  // reset empties the result channel
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ip_neighbor_filter_table nft_chk u_nft_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_table_full   (out_ch.table_full),
  .out_next_hop_mac (out_ch.next_hop_mac),
  .out_ip_ident     (out_ch.ip_ident)
);

/* tb/sv/tb_ip_neighbor_filter_table.sv */
`timescale 1ns / 1ps
// self-checking testbench for ip_neighbor_filter_table: receive filter, neighbour learning,
// transmit next-hop resolution; depends on nft_pkg, nft_in_if/nft_out_if and the block itself
module tb_ip_neighbor_filter_table;
  import nft_pkg::*;

  localparam int N_ENTRIES   = NFT_TABLE_ENTRIES;
  localparam int POOL_SIZE   = 24;
  localparam int POOL_IDX_W  = $clog2(POOL_SIZE);
  localparam int DRAIN_WAIT  = 24;       // margin after the longest scan, which covers every table entry
  localparam int CYCLE_LIMIT = 500000;   // watchdog limit on the whole run
  localparam int HOLD_CYCLES = 300;

  // word kinds on the input channel
  localparam logic KIND_RX = 1'b0;
  localparam logic KIND_TX = 1'b1;
  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic             kind;
    logic [IP_W-1:0]  dest_ip;
    logic [IP_W-1:0]  source_ip;
    logic [MAC_W-1:0] source_mac;
    logic [3:0]       header_words;
    logic [LEN_W-1:0] bytes_available;
    logic [7:0]       protocol;
  } nft_word_t;

  typedef struct {
    nft_status_t      status;
    logic             table_full;
    logic [IP_W-1:0]  next_hop_ip;
    logic [MAC_W-1:0] next_hop_mac;
    logic [15:0]      ip_ident;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [IP_W-1:0] cfg_wdata;

  nft_in_if  in_ch ();
  nft_out_if out_ch ();

  ip_neighbor_filter_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the block: configuration, neighbour table, ident counter
  logic [IP_W-1:0]  own_ip_r, net_mask_r, gw_addr_r;
  logic [IP_W-1:0]  nbr_ip  [N_ENTRIES];
  logic [MAC_W-1:0] nbr_mac [N_ENTRIES];
  int               nbr_count;
  logic [15:0]      ident_next;

  // verdicts of accepted words, oldest first
  verdict_t expected_verdicts[$];
  verdict_t oldest;

  // addresses that recur in traffic; the first 14 share one /24 prefix
  logic [IP_W-1:0] addr_pool [POOL_SIZE];

  int fail_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 6;
  int recv_idle_pct = 62;
  int hold_request = 0;
  int hold_left = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ip_neighbor_filter_table test failed");
      $finish;
    end
  end

  // lowest valid entry holding addr, -1 when absent
  function automatic int find_mapping(logic [IP_W-1:0] addr);
    for (int i = 0; i < nbr_count; i++)
      if (nbr_ip[i] == addr) return i;
    return -1;
  endfunction

  // verdict for one accepted word; advances the shadow state
  function automatic verdict_t predict_verdict(nft_word_t w);
    verdict_t r;
    int idx;
    r.status       = ST_NOT_US;
    r.table_full   = 1'b0;
    r.next_hop_ip  = '0;
    r.next_hop_mac = '0;
    r.ip_ident     = '0;
    if (w.kind == KIND_RX) begin
      if (w.dest_ip != own_ip_r && w.dest_ip != BCAST_IP) begin
        r.status = ST_NOT_US;
      end else if ({w.header_words, 2'b00} > w.bytes_available) begin
        r.status = ST_BAD_LEN;
      end else begin
        // learn or refresh the source mapping, unless the table has no room
        idx = find_mapping(w.source_ip);
        if (idx < 0 && nbr_count >= N_ENTRIES) begin
          r.table_full = 1'b1;
        end else begin
          if (idx < 0) begin
            idx = nbr_count;
            nbr_count++;
          end
          nbr_ip[idx]  = w.source_ip;
          nbr_mac[idx] = w.source_mac;
        end
        r.status = (w.protocol == PROTO_UDP) ? ST_UDP : ST_BAD_PROTO;
      end
    end else begin
      // on-link when the destination shares the gateway's subnet
      r.next_hop_ip = ((w.dest_ip & net_mask_r) == (gw_addr_r & net_mask_r)) ?
                      w.dest_ip : gw_addr_r;
      idx = find_mapping(r.next_hop_ip);
      if (idx >= 0) begin
        r.status       = ST_RESOLVED;
        r.next_hop_mac = nbr_mac[idx];
      end else begin
        r.status = ST_UNRESOLVED;
      end
      r.ip_ident = ident_next;
      ident_next = ident_next + 16'd1;
    end
    return r;
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] r64;
    r64 = {$urandom(), $urandom()};
    return r64[MAC_W-1:0];
  endfunction

  function automatic nft_word_t rx_word(logic [IP_W-1:0] dest, logic [IP_W-1:0] src,
                                        logic [MAC_W-1:0] mac, logic [3:0] ihl,
                                        logic [LEN_W-1:0] avail, logic [7:0] proto);
    nft_word_t w;
    w.kind            = KIND_RX;
    w.dest_ip         = dest;
    w.source_ip       = src;
    w.source_mac      = mac;
    w.header_words    = ihl;
    w.bytes_available = avail;
    w.protocol        = proto;
    return w;
  endfunction

  // mostly well-formed traffic around the address pool, with some noise
  function automatic nft_word_t random_word();
    nft_word_t w;
    int pick;
    w.kind            = ($urandom_range(99) < 30) ? KIND_TX : KIND_RX;
    w.dest_ip         = $urandom();
    w.source_ip       = $urandom();
    w.source_mac      = rand_mac();
    w.header_words    = 4'($urandom_range(15));
    w.bytes_available = LEN_W'($urandom_range(16'hFFFF));
    w.protocol        = 8'($urandom_range(255));
    if (w.kind == KIND_RX) begin
      pick = $urandom_range(99);
      if (pick < 45) w.dest_ip = own_ip_r;
      else if (pick < 80) w.dest_ip = BCAST_IP;
      if ($urandom_range(99) < 85)
        w.source_ip = addr_pool[POOL_IDX_W'($urandom_range(POOL_SIZE-1))];
      if ($urandom_range(99) < 70) w.protocol = PROTO_UDP;
      // header length right at the edge of the bytes present
      pick = $urandom_range(99);
      if (pick < 60)
        w.bytes_available = LEN_W'({w.header_words, 2'b00} + $urandom_range(3));
      else if (pick < 75 && w.header_words != 4'd0)
        w.bytes_available = LEN_W'({w.header_words, 2'b00} - 1);
    end else begin
      pick = $urandom_range(99);
      if (pick < 65) w.dest_ip = addr_pool[POOL_IDX_W'($urandom_range(POOL_SIZE-1))];
      else if (pick < 75) w.dest_ip = BCAST_IP;
      else if (pick < 85) w.dest_ip = gw_addr_r;
    end
    return w;
  endfunction

  // offer one word, predict its verdict once it is taken
  task automatic offer_word(input nft_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.kind            <= w.kind;
    in_ch.dest_ip         <= w.dest_ip;
    in_ch.source_ip       <= w.source_ip;
    in_ch.source_mac      <= w.source_mac;
    in_ch.header_words    <= w.header_words;
    in_ch.bytes_available <= w.bytes_available;
    in_ch.protocol        <= w.protocol;
    do @(posedge clk); while (!in_ch.ready);
    expected_verdicts.push_back(predict_verdict(w));
  endtask

  // stop offering and let every outstanding word come back
  task automatic settle_block();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IP_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_OWN_IP:   own_ip_r   = data;
      CFG_NET_MASK: net_mask_r = data;
      CFG_GW_ADDR:  gw_addr_r  = data;
      default: ;
    endcase
  endtask

  // all three registers, plus a write to the spare index that must be ignored
  task automatic set_config(input logic [IP_W-1:0] own, input logic [IP_W-1:0] mask,
                            input logic [IP_W-1:0] gw);
    write_reg(CFG_OWN_IP, own);
    write_reg(CFG_NET_MASK, mask);
    write_reg(CFG_GW_ADDR, gw);
    write_reg(CFG_UNUSED, $urandom());
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // field extremes, every status, header length boundaries, broadcast overwrite
  task automatic test_directed_cases();
    set_config(32'h0A00_0105, 32'hFFFF_FF00, 32'h0A00_0101);
    // foreign destination is dropped
    offer_word(rx_word(32'h0A00_0199, 32'h0A00_0102, rand_mac(), 4'd5, 16'd20, PROTO_UDP));
    // header one byte longer than the frame
    offer_word(rx_word(own_ip_r, 32'h0A00_0102, rand_mac(), 4'd15, 16'd59, PROTO_UDP));
    offer_word(rx_word(own_ip_r, 32'h0A00_0102, rand_mac(), 4'd1, 16'd3, PROTO_UDP));
    // header exactly fills the frame: learn the gateway
    offer_word(rx_word(own_ip_r, 32'h0A00_0101, 48'h0, 4'd15, 16'd60, PROTO_UDP));
    // zero length header, protocol zero, source zero
    offer_word(rx_word(BCAST_IP, 32'h0, '1, 4'd0, 16'd0, 8'd0));
    // broadcast source replaces the broadcast entry's mac
    offer_word(rx_word(BCAST_IP, BCAST_IP, 48'h0200_1122_3344, 4'd5, 16'hFFFF, 8'd255));
    // known source, new mac
    offer_word(rx_word(own_ip_r, 32'h0A00_0101, 48'h8000_0000_0001, 4'd1, 16'd4, PROTO_UDP));
    // on-link and resolved, via gateway, on-link but unknown
    offer_word(rx_word(own_ip_r, 32'h0A00_0101, 48'h8000_0000_0001, 4'd1, 16'd4, PROTO_UDP));
    begin
      nft_word_t w;
      w = random_word();
      w.kind = KIND_TX; w.dest_ip = 32'h0A00_0101; offer_word(w);
      w.dest_ip = 32'h0808_0808; offer_word(w);
      w.dest_ip = 32'h0A00_01FF; offer_word(w);
      w.dest_ip = 32'h0; offer_word(w);
      w.dest_ip = BCAST_IP; offer_word(w);
    end
  endtask

  // fill the table from the pool, then push two sources that no longer fit
  task automatic test_table_full();
    nft_word_t w;
    for (int i = 0; i < POOL_SIZE && nbr_count < N_ENTRIES; i++)
      if (find_mapping(addr_pool[i]) < 0)
        offer_word(rx_word(own_ip_r, addr_pool[i], rand_mac(), 4'd5, 16'd20, PROTO_UDP));
    offer_word(rx_word(BCAST_IP, addr_pool[POOL_SIZE-2], rand_mac(), 4'd5, 16'd20, PROTO_UDP));
    offer_word(rx_word(own_ip_r, addr_pool[POOL_SIZE-3], rand_mac(), 4'd6, 16'd40, 8'd6));
    // a known source is still refreshed when full
    offer_word(rx_word(own_ip_r, addr_pool[0], rand_mac(), 4'd5, 16'd20, PROTO_UDP));
    w = random_word();
    w.kind    = KIND_TX;
    w.dest_ip = addr_pool[0];
    offer_word(w);
  endtask

  task automatic test_random_traffic(input int count, input int s_idle, input int r_idle,
                                     input logic [IP_W-1:0] own, input logic [IP_W-1:0] mask,
                                     input logic [IP_W-1:0] gw);
    settle_block();
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    set_config(own, mask, gw);
    repeat (count) offer_word(random_word());
  endtask

  // receiver holds off long enough for the block to back up into the input
  task automatic test_backpressure();
    settle_block();
    send_idle_pct = 0;
    recv_idle_pct = 30;
    set_config($urandom(), 32'hFFFF_0000, addr_pool[5]);
    hold_request = HOLD_CYCLES;
    repeat (40) offer_word(random_word());
  endtask

  // result side: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string field, input logic [MAC_W-1:0] want,
                             input logic [MAC_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    end
  endtask

  // every result word against the oldest outstanding verdict
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("result word with no request outstanding");
        fail_count++;
      end else begin
        oldest = expected_verdicts.pop_front();
        check_field("status", oldest.status, out_ch.status);
        check_field("table_full", oldest.table_full, out_ch.table_full);
        check_field("next_hop_ip", oldest.next_hop_ip, out_ch.next_hop_ip);
        check_field("next_hop_mac", oldest.next_hop_mac, out_ch.next_hop_mac);
        check_field("ip_ident", oldest.ip_ident, out_ch.ip_ident);
      end
    end
  end

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_wdata             = '0;
    in_ch.valid           = 1'b0;
    in_ch.kind            = KIND_RX;
    in_ch.dest_ip         = '0;
    in_ch.source_ip       = '0;
    in_ch.source_mac      = '0;
    in_ch.header_words    = '0;
    in_ch.bytes_available = '0;
    in_ch.protocol        = '0;
    out_ch.ready          = 1'b0;

    // state after reset: broadcast entry only
    own_ip_r   = '0;
    net_mask_r = '0;
    gw_addr_r  = '0;
    for (int i = 0; i < N_ENTRIES; i++) begin
      nbr_ip[i]  = '0;
      nbr_mac[i] = '0;
    end
    nbr_ip[0]  = BCAST_IP;
    nbr_mac[0] = '1;
    nbr_count  = 1;
    ident_next = '0;

    // distinct addresses: low suffixes on one subnet, the rest keyed by top byte
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < 14) addr_pool[i] = {24'hC0A807, 4'(i), 4'($urandom_range(15))};
      else addr_pool[i] = {8'(100 + i), 24'($urandom())};
    end
    addr_pool[POOL_SIZE-1] = BCAST_IP;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_table_full();
    // sender mostly busy, receiver stalling; then the reverse; then flat out
    test_random_traffic(640, 6, 62, addr_pool[2], 32'hFFFF_FF00, addr_pool[0]);
    test_random_traffic(640, 62, 6, BCAST_IP, 32'h0, 32'h0);
    test_random_traffic(640, 0, 0, 32'h0, BCAST_IP, BCAST_IP);
    test_backpressure();
    settle_block();

    if (fail_count == 0) begin
      $display("ip_neighbor_filter_table test passed");
    end else begin
      $display("ip_neighbor_filter_table test failed");
    end
    $finish;
  end

endmodule
